/* rtl/ipv4_header_check_top_macros.svh */
// assertion macros shared by the ipv4 header check rtl
`ifndef IPV4_HEADER_CHECK_TOP_MACROS_SVH
`define IPV4_HEADER_CHECK_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define IHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define IHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ihc_pkg.sv */
// types and constants of the ipv4 header check
`default_nettype none

package ihc_pkg;

  // frame byte counter
  localparam int unsigned CntW   = 17;
  localparam logic [CntW-1:0] CntMax = 17'h1ffff;

  // byte offsets of the captured header fields
  localparam logic [CntW-1:0] OFS_VER_IHL   = 17'd0;
  localparam logic [CntW-1:0] OFS_TOTAL_HI  = 17'd2;
  localparam logic [CntW-1:0] OFS_TOTAL_LO  = 17'd3;
  localparam logic [CntW-1:0] OFS_FRAG_HI   = 17'd6;
  localparam logic [CntW-1:0] OFS_FRAG_LO   = 17'd7;
  localparam logic [CntW-1:0] OFS_PROTO     = 17'd9;
  localparam logic [CntW-1:0] OFS_SRC_FIRST = 17'd12;
  localparam logic [CntW-1:0] OFS_SRC_LAST  = 17'd15;
  localparam logic [CntW-1:0] OFS_DST_FIRST = 17'd16;
  localparam logic [CntW-1:0] OFS_DST_LAST  = 17'd19;

  // header field values
  localparam logic [3:0]  VERSION_V4       = 4'd4;
  localparam logic [3:0]  VERSION_V6       = 4'd6;
  localparam logic [CntW-1:0] MIN_HDR_BYTES = 17'd20;
  localparam int unsigned FRAG_MF_BIT      = 13;
  localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_BAD_VERSION   = 4'd1,
    ST_IPV6          = 4'd2,
    ST_SHORT         = 4'd3,
    ST_BAD_HDR_LEN   = 4'd4,
    ST_BAD_TOTAL     = 4'd5,
    ST_TRUNCATED     = 4'd6,
    ST_FRAGMENT      = 4'd7,
    ST_UNKNOWN_PROTO = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    HND_ICMP = 2'd0,
    HND_TCP  = 2'd1,
    HND_UDP  = 2'd2
  } handler_t;

  // header fields as captured so far
  typedef struct packed {
    logic [7:0]  version_ihl;
    logic [15:0] total_len;
    logic [15:0] frag_word;
    logic [7:0]  proto_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } hdr_fields_t;

  // one verdict
  typedef struct packed {
    status_t     status;
    handler_t    handler;
    logic [5:0]  header_bytes;
    logic [16:0] payload_bytes;
    logic        trailing_bytes;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } verdict_t;

endpackage

`default_nettype wire

/* rtl/ipv4_header_check_top.sv */
// top level of the ipv4 header check: byte capture, counter and verdict register
//
//  channel  dir  width  contents
//  s_*      in   8+1    frame byte in tdata, final byte flagged by tlast
//  m_*      out  96     one verdict per frame, fields packed in tdata
//
// one frame byte is taken every cycle while the verdict register is free or drained
// the verdict is registered and appears in the cycle after the final byte; capture and checks happen in the same cycle
// rst clears the byte counter, the captured fields and the verdict valid
// a held verdict stalls input only while m_tready is low
`default_nettype none

module ipv4_header_check_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // frame_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata    // status, handler, header_bytes, payload_bytes,
                                      // trailing_bytes, source_addr, dest_addr, pad
);

  `include "ipv4_header_check_top_macros.svh"

  logic                     accept;
  logic [ihc_pkg::CntW-1:0] byte_count;
  logic [ihc_pkg::CntW-1:0] byte_count_next;
  ihc_pkg::hdr_fields_t     fields;
  ihc_pkg::hdr_fields_t     fields_next;
  ihc_pkg::verdict_t        verdict_next;
  ihc_pkg::verdict_t        result;

  // place one byte into a big-endian word
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    case (lane)
      2'd0:    w[31:24] = b;
      2'd1:    w[23:16] = b;
      2'd2:    w[15:8]  = b;
      2'd3:    w[7:0]   = b;
      default: w = word;
    endcase
    return w;
  endfunction

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // header capture for the current byte
  always_comb begin
    fields_next = fields;
    case (byte_count) inside
      ihc_pkg::OFS_VER_IHL:  fields_next.version_ihl     = s_tdata;
      ihc_pkg::OFS_TOTAL_HI: fields_next.total_len[15:8] = s_tdata;
      ihc_pkg::OFS_TOTAL_LO: fields_next.total_len[7:0]  = s_tdata;
      ihc_pkg::OFS_FRAG_HI:  fields_next.frag_word[15:8] = s_tdata;
      ihc_pkg::OFS_FRAG_LO:  fields_next.frag_word[7:0]  = s_tdata;
      ihc_pkg::OFS_PROTO:    fields_next.proto_byte      = s_tdata;
      [ihc_pkg::OFS_SRC_FIRST:ihc_pkg::OFS_SRC_LAST]:
        fields_next.src_addr = put_byte(fields.src_addr, byte_count[1:0], s_tdata);
      [ihc_pkg::OFS_DST_FIRST:ihc_pkg::OFS_DST_LAST]:
        fields_next.dst_addr = put_byte(fields.dst_addr, byte_count[1:0], s_tdata);
      default: ;
    endcase
  end

  // saturating frame length including this byte
  assign byte_count_next = (byte_count == ihc_pkg::CntMax) ? ihc_pkg::CntMax
                                                           : byte_count + 1'b1;

  ihc_verdict u_verdict (
    .fields    (fields_next),
    .frame_len (byte_count_next),
    .verdict   (verdict_next)
  );

  // frame state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      fields     <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count <= '0;
        fields     <= '0;
      end else begin
        byte_count <= byte_count_next;
        fields     <= fields_next;
      end
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      result <= verdict_next;
    end
  end

  assign m_tdata = {2'b00, result.dest_addr, result.source_addr, result.trailing_bytes,
                    result.payload_bytes, result.header_bytes, result.handler, result.status};

  // checks
  `IHC_ASSERT_NEXT(a_final_byte_gives_verdict, accept && s_tlast, m_tvalid, "no verdict after final byte")
  `IHC_ASSERT_NEXT(a_count_clears_after_frame, accept && s_tlast, byte_count == '0, "byte count not cleared")
  `IHC_ASSERT_NEXT(a_no_spurious_verdict, accept && !s_tlast && (!m_tvalid || m_tready), !m_tvalid, "verdict without final byte")
  `IHC_ASSERT_NOW(a_handler_only_when_ok, m_tvalid && result.status != ihc_pkg::ST_OK, result.handler == ihc_pkg::HND_ICMP, "handler set on failed frame")

endmodule

`default_nettype wire

/* rtl/ihc_verdict.sv */
// verdict logic: header checks, handler choice and payload length
`default_nettype none

module ihc_verdict (
  input  wire ihc_pkg::hdr_fields_t        fields,
  input  wire logic [ihc_pkg::CntW-1:0]   frame_len,
  output ihc_pkg::verdict_t                verdict
);

  logic [3:0]               version;
  logic [5:0]               hdr_bytes;
  logic [ihc_pkg::CntW-1:0] hdr_bytes_ext;
  logic [ihc_pkg::CntW-1:0] total_ext;
  logic                     is_fragment;

  // decoded header fields
  assign version       = fields.version_ihl[7:4];
  assign hdr_bytes     = {fields.version_ihl[3:0], 2'b00};
  assign hdr_bytes_ext = {{(ihc_pkg::CntW-6){1'b0}}, hdr_bytes};
  assign total_ext     = {1'b0, fields.total_len};
  assign is_fragment   = fields.frag_word[ihc_pkg::FRAG_MF_BIT] ||
                         ((fields.frag_word & ihc_pkg::FRAG_OFFSET_MASK) != 16'd0);

  // checks in priority order; lengths and addresses given whatever the status
  always_comb begin
    verdict.status         = ihc_pkg::ST_OK;
    verdict.handler        = ihc_pkg::HND_ICMP;
    verdict.header_bytes   = hdr_bytes;
    verdict.payload_bytes  = (frame_len >= hdr_bytes_ext) ? (frame_len - hdr_bytes_ext)
                                                          : '0;
    verdict.trailing_bytes = (frame_len > total_ext);
    verdict.source_addr    = fields.src_addr;
    verdict.dest_addr      = fields.dst_addr;
    if (version != ihc_pkg::VERSION_V4) begin
      verdict.status = (version == ihc_pkg::VERSION_V6) ? ihc_pkg::ST_IPV6
                                                        : ihc_pkg::ST_BAD_VERSION;
    end else if (frame_len < ihc_pkg::MIN_HDR_BYTES) begin
      verdict.status = ihc_pkg::ST_SHORT;
    end else if (hdr_bytes_ext < ihc_pkg::MIN_HDR_BYTES || frame_len < hdr_bytes_ext) begin
      verdict.status = ihc_pkg::ST_BAD_HDR_LEN;
    end else if (total_ext < hdr_bytes_ext) begin
      verdict.status = ihc_pkg::ST_BAD_TOTAL;
    end else if (frame_len < total_ext) begin
      verdict.status = ihc_pkg::ST_TRUNCATED;
    end else if (is_fragment) begin
      verdict.status = ihc_pkg::ST_FRAGMENT;
    end else begin
      case (fields.proto_byte)
        ihc_pkg::PROTO_ICMP: verdict.handler = ihc_pkg::HND_ICMP;
        ihc_pkg::PROTO_TCP:  verdict.handler = ihc_pkg::HND_TCP;
        ihc_pkg::PROTO_UDP:  verdict.handler = ihc_pkg::HND_UDP;
        default:             verdict.status  = ihc_pkg::ST_UNKNOWN_PROTO;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_ipv4_header_check_top.sv */
// self-checking testbench for the ipv4 header check: frame byte stream in, verdicts checked
`timescale 1ns / 100ps
`default_nettype none

module tb_ipv4_header_check_top;

  // one queued frame byte, or a marker that holds the sender until all verdicts are back
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;           // [3:0] status, [5:4] handler, [11:6] header_bytes,
                                  // [28:12] payload_bytes, [29] trailing_bytes,
                                  // [61:30] source_addr, [93:62] dest_addr, pad

  frame_byte_t         frame_byte_q[$];
  ihc_pkg::verdict_t   expected_verdict_q[$];

  // running copy of the header capture
  logic [ihc_pkg::CntW-1:0] hc_count = '0;
  logic [7:0]               hc_vihl = '0;
  logic [15:0]              hc_total = '0;
  logic [15:0]              hc_frag = '0;
  logic [7:0]               hc_proto = '0;
  logic [31:0]              hc_src = '0;
  logic [31:0]              hc_dst = '0;

  int err_cnt = 0;
  int verdicts_due = 0;
  int got_cnt = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int status_seen[16];

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;
  frame_byte_t next_byte;
  bit next_ok;

  // receiver stall state
  int hold_left = 0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int seg_mode = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  ipv4_header_check_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch in %s at verdict %0d: got 0x%0h, expected 0x%0h",
               what, got_cnt, got_v, exp_v);
  endtask

  // capture one header byte, count it, and on the final byte work out the verdict
  task automatic track_header_byte(input logic [7:0] b, input logic last);
    ihc_pkg::verdict_t v;
    int len;
    int hl;
    int tot;
    int sh;
    logic [3:0] ver;
    if (hc_count == ihc_pkg::OFS_VER_IHL) hc_vihl = b;
    else if (hc_count == ihc_pkg::OFS_TOTAL_HI) hc_total[15:8] = b;
    else if (hc_count == ihc_pkg::OFS_TOTAL_LO) hc_total[7:0] = b;
    else if (hc_count == ihc_pkg::OFS_FRAG_HI) hc_frag[15:8] = b;
    else if (hc_count == ihc_pkg::OFS_FRAG_LO) hc_frag[7:0] = b;
    else if (hc_count == ihc_pkg::OFS_PROTO) hc_proto = b;
    else if (hc_count >= ihc_pkg::OFS_SRC_FIRST && hc_count <= ihc_pkg::OFS_SRC_LAST) begin
      sh = 8 * int'(ihc_pkg::OFS_SRC_LAST - hc_count);
      hc_src[sh +: 8] = b;
    end else if (hc_count >= ihc_pkg::OFS_DST_FIRST && hc_count <= ihc_pkg::OFS_DST_LAST) begin
      sh = 8 * int'(ihc_pkg::OFS_DST_LAST - hc_count);
      hc_dst[sh +: 8] = b;
    end
    // count saturates at the top of the counter
    hc_count = (hc_count < ihc_pkg::CntMax) ? hc_count + 1'b1 : ihc_pkg::CntMax;
    if (!last) return;

    len = int'(hc_count);
    hl = int'(hc_vihl[3:0]) * 4;
    tot = int'(hc_total);
    ver = hc_vihl[7:4];
    v.status = ihc_pkg::ST_OK;
    v.handler = ihc_pkg::HND_ICMP;
    if (ver != ihc_pkg::VERSION_V4)
      v.status = (ver == ihc_pkg::VERSION_V6) ? ihc_pkg::ST_IPV6 : ihc_pkg::ST_BAD_VERSION;
    else if (len < int'(ihc_pkg::MIN_HDR_BYTES)) v.status = ihc_pkg::ST_SHORT;
    else if (hl < int'(ihc_pkg::MIN_HDR_BYTES) || len < hl) v.status = ihc_pkg::ST_BAD_HDR_LEN;
    else if (tot < hl) v.status = ihc_pkg::ST_BAD_TOTAL;
    else if (len < tot) v.status = ihc_pkg::ST_TRUNCATED;
    else if (hc_frag[ihc_pkg::FRAG_MF_BIT] || (hc_frag & ihc_pkg::FRAG_OFFSET_MASK) != 16'h0000)
      v.status = ihc_pkg::ST_FRAGMENT;
    else if (hc_proto == ihc_pkg::PROTO_ICMP) v.handler = ihc_pkg::HND_ICMP;
    else if (hc_proto == ihc_pkg::PROTO_TCP) v.handler = ihc_pkg::HND_TCP;
    else if (hc_proto == ihc_pkg::PROTO_UDP) v.handler = ihc_pkg::HND_UDP;
    else v.status = ihc_pkg::ST_UNKNOWN_PROTO;
    v.header_bytes = 6'(hl);
    v.payload_bytes = (len >= hl) ? 17'(len - hl) : 17'd0;
    v.trailing_bytes = (len > tot);
    v.source_addr = hc_src;
    v.dest_addr = hc_dst;
    expected_verdict_q.push_back(v);
    status_seen[int'(v.status)]++;
    verdicts_due++;

    // next frame starts from a clean capture
    hc_count = '0;
    hc_vihl = '0;
    hc_total = '0;
    hc_frag = '0;
    hc_proto = '0;
    hc_src = '0;
    hc_dst = '0;
  endtask

  // queue one frame: header fields at their offsets, random filler elsewhere
  task automatic queue_frame(input logic [7:0] vihl, input logic [15:0] tot,
                             input logic [15:0] frag, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst, input int len);
    frame_byte_t fb;
    for (int i = 0; i < len; i++) begin
      fb.data = 8'($urandom);
      if (i == int'(ihc_pkg::OFS_VER_IHL)) fb.data = vihl;
      else if (i == int'(ihc_pkg::OFS_TOTAL_HI)) fb.data = tot[15:8];
      else if (i == int'(ihc_pkg::OFS_TOTAL_LO)) fb.data = tot[7:0];
      else if (i == int'(ihc_pkg::OFS_FRAG_HI)) fb.data = frag[15:8];
      else if (i == int'(ihc_pkg::OFS_FRAG_LO)) fb.data = frag[7:0];
      else if (i == int'(ihc_pkg::OFS_PROTO)) fb.data = proto;
      else if (i >= int'(ihc_pkg::OFS_SRC_FIRST) && i <= int'(ihc_pkg::OFS_SRC_LAST))
        fb.data = src[8 * (int'(ihc_pkg::OFS_SRC_LAST) - i) +: 8];
      else if (i >= int'(ihc_pkg::OFS_DST_FIRST) && i <= int'(ihc_pkg::OFS_DST_LAST))
        fb.data = dst[8 * (int'(ihc_pkg::OFS_DST_LAST) - i) +: 8];
      fb.last = (i == len - 1);
      fb.drain = 1'b0;
      frame_byte_q.push_back(fb);
      bytes_queued++;
    end
  endtask

  task automatic queue_drain();
    frame_byte_t fb;
    fb.data = 8'h00;
    fb.last = 1'b0;
    fb.drain = 1'b1;
    frame_byte_q.push_back(fb);
  endtask

  // sender: bursts with random gaps; predicts on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tlast <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_header_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        next_ok = 1'b0;
        if (frame_byte_q.size() != 0 && frame_byte_q[0].drain) begin
          // hold until every pending verdict has come back
          if (got_cnt >= verdicts_due) void'(frame_byte_q.pop_front());
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (frame_byte_q.size() != 0) begin
          next_byte = frame_byte_q.pop_front();
          next_ok = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(80, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
        s_tvalid <= next_ok;
        if (next_ok) begin
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.last;
        end
      end
    end
  end

  // receiver: random stall segments, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && got_cnt >= 10) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else begin
      if (seg_left <= 0) begin
        seg_mode = $urandom_range(2, 0);
        seg_left = $urandom_range(150, 10);
      end
      seg_left--;
      case (seg_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(1, 0));
        end
        default: begin
          m_tready <= ($urandom_range(3, 0) == 0);
        end
      endcase
    end
  end

  // monitor: compare each verdict transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_verdict_q.size() == 0) begin
        report_mismatch("unexpected verdict", longint'(m_tdata[63:0]), 0);
      end else begin
        automatic ihc_pkg::verdict_t want = expected_verdict_q.pop_front();
        if (m_tdata[3:0] != want.status)
          report_mismatch("status", m_tdata[3:0], want.status);
        if (m_tdata[5:4] != want.handler)
          report_mismatch("handler", m_tdata[5:4], want.handler);
        if (m_tdata[11:6] != want.header_bytes)
          report_mismatch("header_bytes", m_tdata[11:6], want.header_bytes);
        if (m_tdata[28:12] != want.payload_bytes)
          report_mismatch("payload_bytes", m_tdata[28:12], want.payload_bytes);
        if (m_tdata[29] != want.trailing_bytes)
          report_mismatch("trailing_bytes", m_tdata[29], want.trailing_bytes);
        if (m_tdata[61:30] != want.source_addr)
          report_mismatch("source_addr", m_tdata[61:30], want.source_addr);
        if (m_tdata[93:62] != want.dest_addr)
          report_mismatch("dest_addr", m_tdata[93:62], want.dest_addr);
      end
      got_cnt <= got_cnt + 1;
    end
  end

  // reset once at the start
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus and end of run
  initial begin
    int ihl;
    int hl;
    int pay;
    int len;
    int tot;
    int sel;
    int rand_start;
    bit mid_drain;
    logic [15:0] frag;
    logic [7:0] proto;
    logic [7:0] vihl;

    mid_drain = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed frames: field extremes and every verdict
    queue_frame(8'h00, 16'd0, 16'h0000, 8'h00, 32'h0, 32'h0, 1);            // version 0
    queue_frame(8'hff, 16'hffff, 16'hffff, 8'hff, 32'hffffffff, 32'hffffffff, 1);
    queue_frame(8'h65, 16'd40, 16'h0000, ihc_pkg::PROTO_TCP, 32'h01020304, 32'h05060708, 40);
    queue_frame(8'h45, 16'd19, 16'h0000, ihc_pkg::PROTO_TCP, 32'h0a000001, 32'h0a000002, 19);
    queue_frame(8'h44, 16'd20, 16'h0000, ihc_pkg::PROTO_TCP, 32'h0a000001, 32'h0a000002, 20);
    queue_frame(8'h4f, 16'd40, 16'h0000, ihc_pkg::PROTO_UDP, 32'hc0a80001, 32'hc0a80002, 40);
    queue_frame(8'h45, 16'd0, 16'h0000, ihc_pkg::PROTO_UDP, 32'hc0a80001, 32'hc0a80002, 20);
    queue_frame(8'h45, 16'd60, 16'h0000, ihc_pkg::PROTO_UDP, 32'hc0a80001, 32'hc0a80002, 40);
    queue_frame(8'h45, 16'd30, 16'h2000, ihc_pkg::PROTO_TCP, 32'h7f000001, 32'h7f000001, 30);
    queue_frame(8'h45, 16'd30, 16'h0001, ihc_pkg::PROTO_TCP, 32'h7f000001, 32'h7f000001, 30);
    queue_frame(8'h45, 16'd30, 16'h4000, ihc_pkg::PROTO_TCP, 32'h7f000001, 32'h7f000001, 30);
    queue_frame(8'h45, 16'd20, 16'h0000, 8'h00, 32'h80000000, 32'h00000001, 20);
    queue_frame(8'h45, 16'd20, 16'h0000, 8'hff, 32'h80000000, 32'h00000001, 20);
    queue_frame(8'h45, 16'd28, 16'h0000, ihc_pkg::PROTO_ICMP, 32'h08080808, 32'h01010101, 28);
    queue_frame(8'h45, 16'd20, 16'h0000, ihc_pkg::PROTO_UDP, 32'h08080808, 32'h01010101, 30);
    queue_frame(8'h4f, 16'd60, 16'h0000, ihc_pkg::PROTO_TCP, 32'hffffffff, 32'h00000000, 60);
    queue_frame(8'h45, 16'hffff, 16'h0000, ihc_pkg::PROTO_TCP, 32'h0, 32'h0, 20);
    queue_drain();

    // random frames: mostly well formed, some broken, some noise
    rand_start = bytes_queued;
    while (bytes_queued - rand_start < 1050) begin
      if (!mid_drain && bytes_queued - rand_start >= 525) begin
        mid_drain = 1'b1;
        queue_drain();
      end
      sel = $urandom_range(9, 0);
      if (sel == 0) begin
        queue_frame(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    $urandom, $urandom, $urandom_range(64, 1));
      end else if (sel == 1) begin
        vihl = {ihc_pkg::VERSION_V4, 4'($urandom_range(15, 0))};
        queue_frame(vihl, 16'($urandom_range(80, 0)), 16'h0000, ihc_pkg::PROTO_TCP,
                    $urandom, $urandom, $urandom_range(80, 1));
      end else begin
        ihl = $urandom_range(15, 5);
        hl = ihl * 4;
        pay = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(48, 1);
        len = hl + pay;
        case ($urandom_range(5, 0))
          0: tot = len - int'($urandom_range(pay, 0));
          1: tot = len + int'($urandom_range(8, 1));
          default: tot = len;
        endcase
        vihl = ($urandom_range(15, 0) == 0) ? {4'($urandom_range(15, 0)), 4'(ihl)}
                                            : {ihc_pkg::VERSION_V4, 4'(ihl)};
        case ($urandom_range(9, 0))
          0: frag = 16'($urandom);
          1: frag = 16'h2000 | 16'($urandom_range(3, 0));
          2: frag = 16'h4000;
          default: frag = 16'h0000;
        endcase
        case ($urandom_range(9, 0))
          0: proto = 8'($urandom);
          1, 2, 3: proto = ihc_pkg::PROTO_ICMP;
          4, 5, 6: proto = ihc_pkg::PROTO_TCP;
          default: proto = ihc_pkg::PROTO_UDP;
        endcase
        queue_frame(vihl, 16'(tot), frag, proto, $urandom, $urandom, len);
      end
    end

    // wait for the stream to drain, then for the last verdicts
    while (frame_byte_q.size() != 0 || s_tvalid) @(posedge clk);
    while (got_cnt < verdicts_due) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_verdict_q.size() != 0)
      report_mismatch("verdicts never delivered", 0, expected_verdict_q.size());

    $display("sent %0d frame bytes in %0d frames with stalls on both sides, %0d verdicts seen",
             bytes_sent, verdicts_due, got_cnt);
    $display("verdicts by status ok/ver/v6/short/hdr/total/trunc/frag/proto: %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    $display("  %0d %0d %0d %0d %0d %0d",
             status_seen[3], status_seen[4], status_seen[5], status_seen[6],
             status_seen[7], status_seen[8]);
    if (err_cnt == 0) begin
      $display("[ipv4_header_check_top] OK");
    end else begin
      $display("[ipv4_header_check_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[ipv4_header_check_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* ipv4_header_check_top.f */
+incdir+rtl
rtl/ihc_pkg.sv
rtl/ihc_verdict.sv
rtl/ipv4_header_check_top.sv
tb/sv/tb_ipv4_header_check_top.sv
